FILE: src/ydec_pkg.sv
// ----------------------------------------------------------------------------
// Yaz0 decompressor package
// Shared constants, status codes and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package ydec_pkg;

  // History window and header geometry.
  localparam int WINDOW_BYTES = 4096;
  localparam int HIST_AW      = $clog2(WINDOW_BYTES);
  localparam int HEADER_BYTES = 16;
  localparam int HDR_IDX_W    = 5;
  localparam int MAGIC_BYTES  = 4;
  localparam int SIZE_FIRST   = 4;
  localparam int SIZE_LAST    = 7;

  // Flag byte and back-reference length encoding.
  localparam int FLAG_BITS      = 8;
  localparam int FLAG_CNT_W     = 4;
  localparam int LEN_W          = 9;
  localparam int LEN_SHORT_BIAS = 2;
  localparam int LEN_LONG_BIAS  = 'h12;

  // Output packing.
  localparam int PACK_LANES = 8;
  localparam int LANE_AW    = $clog2(PACK_LANES);
  localparam int CNT_W      = 4;
  localparam int DATA_W     = 8 * PACK_LANES;

  // Configuration register index carried by the word address bit.
  localparam logic REG_EXPECTED_SIZE = 1'b0;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_DATA      = 3'd0;
  localparam status_t ST_FINISHED  = 3'd1;
  localparam status_t ST_BAD_MAGIC = 3'd2;
  localparam status_t ST_SIZE      = 3'd3;
  localparam status_t ST_BAD_DIST  = 3'd4;
  localparam status_t ST_OVERLONG  = 3'd5;
  localparam status_t ST_SHORT     = 3'd6;

  // The four magic bytes "Yaz0".
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h59;
      2'd1:    b = 8'h61;
      2'd2:    b = 8'h7A;
      default: b = 8'h30;
    endcase
    return b;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    hdr_step;
    logic    load_flags;
    logic    store_ref1;
    logic    store_ref2;
    logic    store_ref3;
    logic    lit_emit;
    logic    copy_start;
    logic    copy_step;
    logic    advance;
    logic    flush;
    logic    rearm;
    status_t term;
  } ydec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic magic_bad;
    logic size_bad;
    logic hdr_end;
    logic flag_msb;
    logic n_zero;
    logic prod_ge_exp;
    logic dist_bad;
    logic len_bad;
    logic copy_last;
    logic adv_flags_zero;
    logic adv_msb;
    logic can_append;
    logic out_free;
    logic pack_empty;
  } ydec_sts_t;

endpackage

FILE: src/ydec_ctrl.sv
// ----------------------------------------------------------------------------
// Yaz0 decompressor controller
// Sequences each accepted byte through decode, reference check, copy,
// flag advance and result flush, and tracks the parse phase of the stream.
// ----------------------------------------------------------------------------
module ydec_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ydec_pkg::ydec_sts_t sts,
  output ydec_pkg::ydec_cmd_t cmd
);
  import ydec_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_CHECK, S_COPY, S_ADV, S_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    PH_HEADER, PH_FLAG, PH_LIT, PH_REF1, PH_REF2, PH_REF3
  } phase_t;

  state_t  state_r, state_nxt;
  phase_t  phase_r, phase_nxt;
  logic    done_r, done_nxt;
  status_t term_r, term_nxt;
  logic    fin;
  status_t fin_code;
  status_t fin_eff;

  assign in_tready = (state_r == S_IDLE);

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    done_nxt  = done_r;
    term_nxt  = term_r;
    cmd       = '0;
    cmd.term  = term_r;
    fin       = 1'b0;
    fin_code  = ST_DATA;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        if (done_r) begin
          // A closed stream ignores bytes until the one that ends it.
          if (sts.last) begin
            cmd.rearm = 1'b1;
            done_nxt  = 1'b0;
            phase_nxt = PH_HEADER;
          end
          state_nxt = S_IDLE;
        end else begin
          unique case (phase_r)
            PH_HEADER: begin
              if (sts.magic_bad) begin
                fin      = 1'b1;
                fin_code = ST_BAD_MAGIC;
              end else begin
                cmd.hdr_step = 1'b1;
                fin          = 1'b1;
                if (sts.size_bad) begin
                  fin_code = ST_SIZE;
                end else if (sts.hdr_end && sts.prod_ge_exp) begin
                  fin_code = ST_FINISHED;
                end else if (sts.hdr_end) begin
                  phase_nxt = PH_FLAG;
                end
              end
            end
            PH_FLAG: begin
              cmd.load_flags = 1'b1;
              phase_nxt      = sts.flag_msb ? PH_LIT : PH_REF1;
              fin            = 1'b1;
            end
            PH_LIT: begin
              if (sts.prod_ge_exp) begin
                fin      = 1'b1;
                fin_code = ST_OVERLONG;
              end else begin
                cmd.lit_emit = 1'b1;
                state_nxt    = S_ADV;
              end
            end
            PH_REF1: begin
              cmd.store_ref1 = 1'b1;
              phase_nxt      = PH_REF2;
              fin            = 1'b1;
            end
            PH_REF2: begin
              cmd.store_ref2 = 1'b1;
              if (sts.n_zero) begin
                phase_nxt = PH_REF3;
                fin       = 1'b1;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            PH_REF3: begin
              cmd.store_ref3 = 1'b1;
              state_nxt      = S_CHECK;
            end
            default: begin
              phase_nxt = PH_HEADER;
              fin       = 1'b1;
            end
          endcase
        end
      end

      // Distance is checked before length.
      S_CHECK: begin
        if (sts.dist_bad) begin
          fin      = 1'b1;
          fin_code = ST_BAD_DIST;
        end else if (sts.len_bad) begin
          fin      = 1'b1;
          fin_code = ST_OVERLONG;
        end else begin
          cmd.copy_start = 1'b1;
          state_nxt      = S_COPY;
        end
      end

      // One history byte per cycle while the packer can take it.
      S_COPY: begin
        if (sts.can_append) begin
          cmd.copy_step = 1'b1;
          if (sts.copy_last) begin
            state_nxt = S_ADV;
          end
        end
      end

      S_ADV: begin
        cmd.advance = 1'b1;
        fin         = 1'b1;
        if (sts.prod_ge_exp) begin
          fin_code = ST_FINISHED;
        end else if (sts.adv_flags_zero) begin
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt = sts.adv_msb ? PH_LIT : PH_REF1;
        end
      end

      S_FLUSH: begin
        if (sts.pack_empty && (term_r == ST_DATA)) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // End of the byte's work: settle the final status and stream state.
    fin_eff = ((fin_code == ST_DATA) && sts.last) ? ST_SHORT : fin_code;
    if (fin) begin
      term_nxt  = fin_eff;
      state_nxt = S_FLUSH;
      if (fin_eff != ST_DATA) begin
        if (sts.last) begin
          cmd.rearm = 1'b1;
          phase_nxt = PH_HEADER;
          done_nxt  = 1'b0;
        end else begin
          done_nxt = 1'b1;
        end
      end
    end
  end

  // State and registered control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_HEADER;
      done_r  <= 1'b0;
      term_r  <= ST_DATA;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      term_r  <= term_nxt;
    end
  end

endmodule

FILE: src/ydec_dp.sv
// ----------------------------------------------------------------------------
// Yaz0 decompressor datapath
// Holds the history window memory, the header and flag registers, the
// counters, the output byte packer and the output register.
// ----------------------------------------------------------------------------
module ydec_dp #(
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic [31:0]         expected_size,
  input  ydec_pkg::ydec_cmd_t cmd,
  output ydec_pkg::ydec_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_data,
  output logic [3:0]          out_count,
  output logic                out_last,
  output logic [2:0]          out_status
);
  import ydec_pkg::*;

  // Latched input byte.
  logic [7:0]            byte_r;
  logic                  last_r;

  // Parse state.
  logic [HIST_AW-1:0]    hist_pos_r;
  logic [31:0]           produced_r;
  logic [HDR_IDX_W-1:0]  hdr_idx_r;
  logic [31:0]           hdr_size_r;
  logic [FLAG_BITS-1:0]  flag_bits_r;
  logic [FLAG_CNT_W-1:0] flags_left_r;
  logic [7:0]            ref_first_r;
  logic [7:0]            ref_second_r;
  logic [LEN_W-1:0]      len_r;
  logic [HIST_AW-1:0]    src_r;

  // History window.
  logic [7:0]            hist_mem [WINDOW_BYTES];
  logic [7:0]            rd_q_r;
  logic                  byp_r;
  logic [7:0]            byp_d_r;

  // Packer and output register.
  logic [7:0]            pack_r [PACK_LANES];
  logic [CNT_W-1:0]      pack_cnt_r;
  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_data_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_last_r;
  status_t               out_status_r;

  logic [HIST_AW-1:0]    ref_dist;
  logic [HIST_AW-1:0]    start_src;
  logic [HIST_AW-1:0]    rd_addr;
  logic [31:0]           size_nxt;
  logic [7:0]            hist_rd;
  logic [7:0]            app_byte;
  logic                  append;
  logic                  pack_full;
  logic                  out_free;
  logic [DATA_W-1:0]     pack_word;
  logic                  in_size_field;

  assign ref_dist      = {ref_first_r[3:0], ref_second_r};
  assign start_src     = hist_pos_r - ref_dist - HIST_AW'(1);
  assign size_nxt      = {hdr_size_r[23:0], byte_r};
  assign hist_rd       = byp_r ? byp_d_r : rd_q_r;
  assign append        = cmd.lit_emit | cmd.copy_step;
  assign app_byte      = cmd.copy_step ? hist_rd : byte_r;
  assign pack_full     = (pack_cnt_r == CNT_W'(BYTES_PER_RESULT));
  assign out_free      = !out_valid_r || out_ready;
  assign in_size_field = (hdr_idx_r >= HDR_IDX_W'(SIZE_FIRST)) &&
                         (hdr_idx_r <= HDR_IDX_W'(SIZE_LAST));

  // The copy source advances only when a byte is taken, so a stall rereads it.
  always_comb begin
    if (cmd.copy_start) begin
      rd_addr = start_src;
    end else if (cmd.copy_step) begin
      rd_addr = src_r + HIST_AW'(1);
    end else begin
      rd_addr = src_r;
    end
  end

  always_comb begin
    for (int i = 0; i < PACK_LANES; i++) begin
      pack_word[8*i +: 8] = pack_r[i];
    end
  end

  // Status toward the controller.
  always_comb begin
    sts                = '0;
    sts.last           = last_r;
    sts.magic_bad      = (hdr_idx_r < HDR_IDX_W'(MAGIC_BYTES)) &&
                         (byte_r != magic_byte(hdr_idx_r[1:0]));
    sts.size_bad       = (hdr_idx_r == HDR_IDX_W'(SIZE_LAST)) &&
                         (size_nxt != expected_size);
    sts.hdr_end        = (hdr_idx_r == HDR_IDX_W'(HEADER_BYTES - 1));
    sts.flag_msb       = byte_r[7];
    sts.n_zero         = (ref_first_r[7:4] == 4'd0);
    sts.prod_ge_exp    = (produced_r >= expected_size);
    sts.dist_bad       = ({20'd0, ref_dist} >= produced_r);
    sts.len_bad        = (({1'b0, produced_r} + 33'(len_r)) > {1'b0, expected_size});
    sts.copy_last      = (len_r == LEN_W'(1));
    sts.adv_flags_zero = (flags_left_r <= FLAG_CNT_W'(1));
    sts.adv_msb        = flag_bits_r[FLAG_BITS-2];
    sts.can_append     = !pack_full || out_free;
    sts.out_free       = out_free;
    sts.pack_empty     = (pack_cnt_r == '0);
  end

  // Parse state: cleared at reset and when a new stream is armed.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.rearm) begin
      hist_pos_r   <= '0;
      produced_r   <= '0;
      hdr_idx_r    <= '0;
      hdr_size_r   <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      ref_first_r  <= '0;
      ref_second_r <= '0;
    end else begin
      if (cmd.hdr_step) begin
        if (in_size_field) begin
          hdr_size_r <= size_nxt;
        end
        hdr_idx_r <= hdr_idx_r + HDR_IDX_W'(1);
      end
      if (cmd.load_flags) begin
        flag_bits_r  <= byte_r;
        flags_left_r <= FLAG_CNT_W'(FLAG_BITS);
      end
      if (cmd.store_ref1) begin
        ref_first_r <= byte_r;
      end
      if (cmd.store_ref2) begin
        ref_second_r <= byte_r;
      end
      if (append) begin
        hist_pos_r <= hist_pos_r + HIST_AW'(1);
        produced_r <= produced_r + 32'd1;
      end
      if (cmd.advance) begin
        flag_bits_r <= {flag_bits_r[FLAG_BITS-2:0], 1'b0};
        if (flags_left_r != '0) begin
          flags_left_r <= flags_left_r - FLAG_CNT_W'(1);
        end
      end
    end
  end

  // Latched byte, reference length and copy source.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (cmd.store_ref2) begin
      len_r <= LEN_W'(ref_first_r[7:4]) + LEN_W'(LEN_SHORT_BIAS);
    end else if (cmd.store_ref3) begin
      len_r <= LEN_W'(byte_r) + LEN_W'(LEN_LONG_BIAS);
    end else if (cmd.copy_step) begin
      len_r <= len_r - LEN_W'(1);
    end
    src_r <= rd_addr;
  end

  // History window with a bypass for a read of the entry being written.
  always_ff @(posedge clk) begin
    if (append) begin
      hist_mem[hist_pos_r] <= app_byte;
    end
    rd_q_r  <= hist_mem[rd_addr];
    byp_r   <= append && (rd_addr == hist_pos_r);
    byp_d_r <= app_byte;
  end

  // Packer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PACK_LANES; i++) begin
        pack_r[i] <= '0;
      end
      pack_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((append && pack_full) || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (append) begin
        if (pack_full) begin
          // Hand the full word on and start a new one with this byte.
          out_data_r   <= pack_word;
          out_cnt_r    <= pack_cnt_r;
          out_last_r   <= 1'b0;
          out_status_r <= ST_DATA;
          for (int i = 1; i < PACK_LANES; i++) begin
            pack_r[i] <= '0;
          end
          pack_r[0]  <= app_byte;
          pack_cnt_r <= CNT_W'(1);
        end else begin
          pack_r[pack_cnt_r[LANE_AW-1:0]] <= app_byte;
          pack_cnt_r <= pack_cnt_r + CNT_W'(1);
        end
      end
      if (cmd.flush) begin
        out_data_r   <= pack_word;
        out_cnt_r    <= pack_cnt_r;
        out_last_r   <= 1'b1;
        out_status_r <= cmd.term;
        for (int i = 0; i < PACK_LANES; i++) begin
          pack_r[i] <= '0;
        end
        pack_cnt_r <= '0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_count  = out_cnt_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

FILE: src/yaz0_stream_decompressor.sv
// ----------------------------------------------------------------------------
// Yaz0 stream decompressor
// Top level: configuration register port, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
// The compressed stream, header included, enters one byte per request on the
// in_ channel; in_tlast marks the final byte. Results leave on the out_
// channel: up to BYTES_PER_RESULT bytes in out_tdata, with a status code in
// out_tuser and out_tlast on the last result caused by an input byte.
// expected_size must be written by the user through the cfg_ port while the
// block is idle; the block itself does not enforce this. A header, flag or
// reference-prefix byte goes through decode and flush, a literal adds flag
// advance, and the byte that completes a reference adds reference check,
// copy and flag advance; the history memory gives the copy one byte per
// cycle; when the receiver stalls with a full word waiting, the copy holds.
// The output register lets the next byte be taken while a result waits.
// Reset clears the parse state and expected_size; the history window is
// not cleared, as a stream only reads back bytes it has written itself.
// ----------------------------------------------------------------------------
module yaz0_stream_decompressor #(
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,    // last_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // [63:0] out_data, [67:64] byte_count, rest zero
  output logic        out_tlast,   // run_last
  output logic [2:0]  out_tuser,   // [2:0] status
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ydec_pkg::*;

  logic [31:0] expected_size_r;
  logic        cfg_wr;
  ydec_cmd_t   cmd;
  ydec_sts_t   sts;
  logic [63:0] out_data;
  logic [3:0]  out_count;

  // Register access: the word address bit selects the register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_EXPECTED_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == REG_EXPECTED_SIZE) ? expected_size_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_size_r <= '0;
    end else if (cfg_wr) begin
      expected_size_r <= cfg_pwdata;
    end
  end

  ydec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ydec_dp #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte       (in_tdata),
    .in_last       (in_tlast),
    .expected_size (expected_size_r),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_data),
    .out_count     (out_count),
    .out_last      (out_tlast),
    .out_status    (out_tuser)
  );

  assign out_tdata = {4'd0, out_count, out_data};

endmodule
